/* rtl/cpt_pkg.sv */
// Shared types, character and token codes, and punctuator lookup functions.
`timescale 1ns / 1ps
package cpt_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int OUT_POS_W = 16;

  // Result kinds.
  localparam logic [1:0] RK_TOKEN   = 2'd0;
  localparam logic [1:0] RK_END     = 2'd1;
  localparam logic [1:0] RK_UNTERM  = 2'd2;
  localparam logic [1:0] RK_BADCHAR = 2'd3;

  // Scan modes.
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_LINE       = 2'd1;
  localparam logic [1:0] MODE_BLOCK      = 2'd2;
  localparam logic [1:0] MODE_BLOCK_STAR = 2'd3;

  // Held byte counts.
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;

  // Characters.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Token codes.
  localparam logic [5:0] TK_SHL_ASSIGN  = 6'd0;
  localparam logic [5:0] TK_SHR_ASSIGN  = 6'd1;
  localparam logic [5:0] TK_LAND_ASSIGN = 6'd2;
  localparam logic [5:0] TK_LOR_ASSIGN  = 6'd3;
  localparam logic [5:0] TK_ELLIPSIS    = 6'd4;
  localparam logic [5:0] TK_ADD_ASSIGN  = 6'd5;
  localparam logic [5:0] TK_SUB_ASSIGN  = 6'd6;
  localparam logic [5:0] TK_MUL_ASSIGN  = 6'd7;
  localparam logic [5:0] TK_DIV_ASSIGN  = 6'd8;
  localparam logic [5:0] TK_MOD_ASSIGN  = 6'd9;
  localparam logic [5:0] TK_NE          = 6'd10;
  localparam logic [5:0] TK_OR_ASSIGN   = 6'd11;
  localparam logic [5:0] TK_AND_ASSIGN  = 6'd12;
  localparam logic [5:0] TK_XOR_ASSIGN  = 6'd13;
  localparam logic [5:0] TK_GE          = 6'd14;
  localparam logic [5:0] TK_LE          = 6'd15;
  localparam logic [5:0] TK_EQEQ        = 6'd16;
  localparam logic [5:0] TK_INC         = 6'd17;
  localparam logic [5:0] TK_DEC         = 6'd18;
  localparam logic [5:0] TK_SHR         = 6'd19;
  localparam logic [5:0] TK_SHL         = 6'd20;
  localparam logic [5:0] TK_LAND        = 6'd21;
  localparam logic [5:0] TK_LOR         = 6'd22;
  localparam logic [5:0] TK_ARROW       = 6'd23;
  localparam logic [5:0] TK_PLUS        = 6'd24;
  localparam logic [5:0] TK_MINUS       = 6'd25;
  localparam logic [5:0] TK_STAR        = 6'd26;
  localparam logic [5:0] TK_SLASH       = 6'd27;
  localparam logic [5:0] TK_BSLASH      = 6'd28;
  localparam logic [5:0] TK_PCT         = 6'd29;
  localparam logic [5:0] TK_LBRACE      = 6'd30;
  localparam logic [5:0] TK_RBRACE      = 6'd31;
  localparam logic [5:0] TK_LBRACK      = 6'd32;
  localparam logic [5:0] TK_RBRACK      = 6'd33;
  localparam logic [5:0] TK_LPAREN      = 6'd34;
  localparam logic [5:0] TK_RPAREN      = 6'd35;
  localparam logic [5:0] TK_PIPE        = 6'd36;
  localparam logic [5:0] TK_AMP         = 6'd37;
  localparam logic [5:0] TK_CARET       = 6'd38;
  localparam logic [5:0] TK_ASSIGN      = 6'd39;
  localparam logic [5:0] TK_GT          = 6'd40;
  localparam logic [5:0] TK_LT          = 6'd41;
  localparam logic [5:0] TK_BANG        = 6'd42;
  localparam logic [5:0] TK_QUEST       = 6'd43;
  localparam logic [5:0] TK_TILDE       = 6'd44;
  localparam logic [5:0] TK_COMMA       = 6'd45;
  localparam logic [5:0] TK_DOT         = 6'd46;
  localparam logic [5:0] TK_COLON       = 6'd47;
  localparam logic [5:0] TK_SEMI        = 6'd48;
  localparam logic [5:0] TK_MAX         = TK_SEMI;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
  } lookup_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  ttype;
    logic [15:0] row;
    logic [15:0] col;
  } res_t;

  // Up to three results caused by one request.
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      item;
  } bundle_t;

  // Scanner control state apart from the position counters.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] held;
    logic [1:0] mode;
    logic       drop;
  } scan_t;

  function automatic lookup_t single_code(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      CH_PLUS:   r.code = TK_PLUS;
      CH_MINUS:  r.code = TK_MINUS;
      CH_STAR:   r.code = TK_STAR;
      CH_SLASH:  r.code = TK_SLASH;
      CH_BSLASH: r.code = TK_BSLASH;
      CH_PCT:    r.code = TK_PCT;
      CH_LBRACE: r.code = TK_LBRACE;
      CH_RBRACE: r.code = TK_RBRACE;
      CH_LBRACK: r.code = TK_LBRACK;
      CH_RBRACK: r.code = TK_RBRACK;
      CH_LPAREN: r.code = TK_LPAREN;
      CH_RPAREN: r.code = TK_RPAREN;
      CH_PIPE:   r.code = TK_PIPE;
      CH_AMP:    r.code = TK_AMP;
      CH_CARET:  r.code = TK_CARET;
      CH_EQ:     r.code = TK_ASSIGN;
      CH_GT:     r.code = TK_GT;
      CH_LT:     r.code = TK_LT;
      CH_BANG:   r.code = TK_BANG;
      CH_QUEST:  r.code = TK_QUEST;
      CH_TILDE:  r.code = TK_TILDE;
      CH_COMMA:  r.code = TK_COMMA;
      CH_DOT:    r.code = TK_DOT;
      CH_COLON:  r.code = TK_COLON;
      CH_SEMI:   r.code = TK_SEMI;
      default: begin
        r.hit  = 1'b0;
        r.code = TK_SHL_ASSIGN;
      end
    endcase
    return r;
  endfunction

  function automatic lookup_t eq_code(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      CH_PLUS:  r.code = TK_ADD_ASSIGN;
      CH_MINUS: r.code = TK_SUB_ASSIGN;
      CH_STAR:  r.code = TK_MUL_ASSIGN;
      CH_SLASH: r.code = TK_DIV_ASSIGN;
      CH_PCT:   r.code = TK_MOD_ASSIGN;
      CH_BANG:  r.code = TK_NE;
      CH_PIPE:  r.code = TK_OR_ASSIGN;
      CH_AMP:   r.code = TK_AND_ASSIGN;
      CH_CARET: r.code = TK_XOR_ASSIGN;
      CH_GT:    r.code = TK_GE;
      CH_LT:    r.code = TK_LE;
      CH_EQ:    r.code = TK_EQEQ;
      default: begin
        r.hit  = 1'b0;
        r.code = TK_SHL_ASSIGN;
      end
    endcase
    return r;
  endfunction

  function automatic lookup_t twin_code(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      CH_PLUS:  r.code = TK_INC;
      CH_MINUS: r.code = TK_DEC;
      CH_GT:    r.code = TK_SHR;
      CH_LT:    r.code = TK_SHL;
      CH_AMP:   r.code = TK_LAND;
      CH_PIPE:  r.code = TK_LOR;
      default: begin
        r.hit  = 1'b0;
        r.code = TK_SHL_ASSIGN;
      end
    endcase
    return r;
  endfunction

  function automatic lookup_t triple_code(input logic [7:0] c);
    lookup_t r;
    r.hit = 1'b1;
    case (c)
      CH_LT:   r.code = TK_SHL_ASSIGN;
      CH_GT:   r.code = TK_SHR_ASSIGN;
      CH_AMP:  r.code = TK_LAND_ASSIGN;
      CH_PIPE: r.code = TK_LOR_ASSIGN;
      default: begin
        r.hit  = 1'b0;
        r.code = TK_SHL_ASSIGN;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic res_t make_tok(input logic [5:0] code);
    res_t r;
    r.kind  = RK_TOKEN;
    r.ttype = code;
    r.row   = '0;
    r.col   = '0;
    return r;
  endfunction

endpackage

/* rtl/cpt_if.sv */
// Valid/ready channel interfaces for source bytes and tokenizer results.
`timescale 1ns / 1ps
interface cpt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink (input valid, input ch, input at_end, output ready);
endinterface

interface cpt_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [5:0]  token_type;
  logic [15:0] err_row;
  logic [15:0] err_col;
  logic        run_last;

  modport source (output valid, output result_kind, output token_type, output err_row,
                  output err_col, output run_last, input ready);
  modport sink (input valid, input result_kind, input token_type, input err_row,
                input err_col, input run_last, output ready);
endinterface

/* rtl/cpt_step.sv */
// Next-state and result logic for one source byte.
`timescale 1ns / 1ps
module cpt_step #(
  parameter int POS_WIDTH = cpt_pkg::POS_WIDTH_DEF
) (
  input  cpt_pkg::scan_t         st,
  input  logic [POS_WIDTH-1:0]   line,
  input  logic [POS_WIDTH-1:0]   col,
  input  logic [7:0]             ch,
  input  logic                   at_end,
  output cpt_pkg::scan_t         st_next,
  output logic [POS_WIDTH-1:0]   line_next,
  output logic [POS_WIDTH-1:0]   col_next,
  output cpt_pkg::bundle_t       bundle
);

  localparam int EXT_W = (POS_WIDTH > cpt_pkg::OUT_POS_W) ? POS_WIDTH : cpt_pkg::OUT_POS_W;
  localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  function automatic logic [15:0] sat16(input logic [POS_WIDTH-1:0] p);
    logic [EXT_W-1:0] e;
    e = EXT_W'(p);
    return (e > EXT_W'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  logic [15:0] row16;
  logic [15:0] col16;

  assign row16 = sat16(line);
  assign col16 = sat16(col);

  always_comb begin
    cpt_pkg::res_t   [2:0] r;
    logic [1:0]            n;
    logic                  run_first;
    logic                  ending;
    logic [7:0]            h;
    cpt_pkg::lookup_t      sgl_h;
    cpt_pkg::lookup_t      eq_h;
    cpt_pkg::lookup_t      twin_h;
    cpt_pkg::lookup_t      tri_h;
    cpt_pkg::lookup_t      sgl_c;
    cpt_pkg::lookup_t      eq_c;

    r         = '0;
    n         = 2'd0;
    run_first = 1'b0;
    st_next   = st;
    line_next = line;
    col_next  = col;
    ending    = at_end || (ch == cpt_pkg::CH_NUL);
    h         = st.held;
    sgl_h     = cpt_pkg::single_code(h);
    eq_h      = cpt_pkg::eq_code(h);
    twin_h    = cpt_pkg::twin_code(h);
    tri_h     = cpt_pkg::triple_code(h);
    sgl_c     = cpt_pkg::single_code(ch);
    eq_c      = cpt_pkg::eq_code(ch);

    if (ending) begin
      if (!st.drop) begin
        if ((st.mode == cpt_pkg::MODE_BLOCK) || (st.mode == cpt_pkg::MODE_BLOCK_STAR)) begin
          r[n] = '{kind: cpt_pkg::RK_UNTERM, ttype: 6'd0, row: row16, col: col16};
          n = n + 2'd1;
        end else begin
          if (st.count == cpt_pkg::HELD_ONE) begin
            r[n] = cpt_pkg::make_tok(sgl_h.code);
            n = n + 2'd1;
          end else if (st.count != cpt_pkg::HELD_NONE) begin
            if (h == cpt_pkg::CH_DOT) begin
              r[n] = cpt_pkg::make_tok(cpt_pkg::TK_DOT);
              n = n + 2'd1;
              r[n] = cpt_pkg::make_tok(cpt_pkg::TK_DOT);
              n = n + 2'd1;
            end else begin
              r[n] = cpt_pkg::make_tok(twin_h.code);
              n = n + 2'd1;
            end
          end
          r[n] = '{kind: cpt_pkg::RK_END, ttype: 6'd0, row: 16'd0, col: 16'd0};
          n = n + 2'd1;
        end
      end
      st_next.count = cpt_pkg::HELD_NONE;
      st_next.mode  = cpt_pkg::MODE_NORMAL;
      st_next.drop  = 1'b0;
      line_next     = POS_ONE;
      col_next      = POS_ONE;
    end else begin
      if (!st.drop) begin
        case (st.mode)
          cpt_pkg::MODE_LINE: begin
            if (ch == cpt_pkg::CH_LF) begin
              st_next.mode = cpt_pkg::MODE_NORMAL;
            end
          end
          cpt_pkg::MODE_BLOCK: begin
            if (ch == cpt_pkg::CH_STAR) begin
              st_next.mode = cpt_pkg::MODE_BLOCK_STAR;
            end
          end
          cpt_pkg::MODE_BLOCK_STAR: begin
            if (ch == cpt_pkg::CH_SLASH) begin
              st_next.mode = cpt_pkg::MODE_NORMAL;
            end else if (ch != cpt_pkg::CH_STAR) begin
              st_next.mode = cpt_pkg::MODE_BLOCK;
            end
          end
          default: begin
            st_next.mode  = cpt_pkg::MODE_NORMAL;
            st_next.count = cpt_pkg::HELD_NONE;
            case (st.count)
              cpt_pkg::HELD_NONE: begin
                run_first = 1'b1;
              end
              cpt_pkg::HELD_ONE: begin
                if ((h == cpt_pkg::CH_SLASH) && (ch == cpt_pkg::CH_SLASH)) begin
                  st_next.mode = cpt_pkg::MODE_LINE;
                end else if ((h == cpt_pkg::CH_SLASH) && (ch == cpt_pkg::CH_STAR)) begin
                  st_next.mode = cpt_pkg::MODE_BLOCK;
                end else if ((ch == cpt_pkg::CH_EQ) && eq_h.hit) begin
                  r[n] = cpt_pkg::make_tok(eq_h.code);
                  n = n + 2'd1;
                end else if ((ch == h) && (tri_h.hit || (h == cpt_pkg::CH_DOT))) begin
                  st_next.count = cpt_pkg::HELD_ONE + 2'd1;
                end else if ((ch == h) && twin_h.hit) begin
                  r[n] = cpt_pkg::make_tok(twin_h.code);
                  n = n + 2'd1;
                end else if ((h == cpt_pkg::CH_MINUS) && (ch == cpt_pkg::CH_GT)) begin
                  r[n] = cpt_pkg::make_tok(cpt_pkg::TK_ARROW);
                  n = n + 2'd1;
                end else begin
                  r[n] = cpt_pkg::make_tok(sgl_h.code);
                  n = n + 2'd1;
                  run_first = 1'b1;
                end
              end
              default: begin
                if (h == cpt_pkg::CH_DOT) begin
                  if (ch == cpt_pkg::CH_DOT) begin
                    r[n] = cpt_pkg::make_tok(cpt_pkg::TK_ELLIPSIS);
                    n = n + 2'd1;
                  end else begin
                    r[n] = cpt_pkg::make_tok(cpt_pkg::TK_DOT);
                    n = n + 2'd1;
                    r[n] = cpt_pkg::make_tok(cpt_pkg::TK_DOT);
                    n = n + 2'd1;
                    run_first = 1'b1;
                  end
                end else if (ch == cpt_pkg::CH_EQ) begin
                  r[n] = cpt_pkg::make_tok(tri_h.code);
                  n = n + 2'd1;
                end else begin
                  r[n] = cpt_pkg::make_tok(twin_h.code);
                  n = n + 2'd1;
                  run_first = 1'b1;
                end
              end
            endcase
            if (run_first) begin
              if (cpt_pkg::is_space(ch)) begin
                st_next.count = cpt_pkg::HELD_NONE;
              end else if (eq_c.hit || (ch == cpt_pkg::CH_DOT)) begin
                st_next.held  = ch;
                st_next.count = cpt_pkg::HELD_ONE;
              end else if (sgl_c.hit) begin
                r[n] = cpt_pkg::make_tok(sgl_c.code);
                n = n + 2'd1;
              end else begin
                r[n] = '{kind: cpt_pkg::RK_BADCHAR, ttype: 6'd0, row: row16, col: col16};
                n = n + 2'd1;
                st_next.drop = 1'b1;
              end
            end
          end
        endcase
      end
      if (ch == cpt_pkg::CH_LF) begin
        line_next = (line != POS_MAX) ? line + POS_ONE : line;
        col_next  = POS_ONE;
      end else begin
        col_next = (col != POS_MAX) ? col + POS_ONE : col;
      end
    end

    bundle.cnt  = n;
    bundle.item = r;
  end

endmodule

/* rtl/cpt_emit.sv */
// Result register that holds one bundle and hands its results out one per cycle while tokens is ready.
`timescale 1ns / 1ps
module cpt_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cpt_pkg::bundle_t   bundle,
  output logic               can_load,
  cpt_token_if.source        tokens
);

  logic             busy;
  logic [1:0]       idx;
  cpt_pkg::bundle_t held;
  cpt_pkg::res_t    cur;
  logic             last;
  logic             take;

  assign cur      = held.item[idx];
  assign last     = (idx == (held.cnt - 2'd1));
  assign take     = busy && tokens.ready;
  assign can_load = !busy || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take && last) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  assign tokens.valid       = busy;
  assign tokens.result_kind = cur.kind;
  assign tokens.token_type  = cur.ttype;
  assign tokens.err_row     = cur.row;
  assign tokens.err_col     = cur.col;
  assign tokens.run_last    = last;

endmodule

/* rtl/c_punctuator_tokenizer.sv */
// Top level of the C punctuator tokenizer.
`timescale 1ns / 1ps
// The tokenizer takes one source byte per request on text and returns
// punctuator tokens, an end token, or an error with its row and column on
// tokens, one result per cycle while tokens is ready, with run_last marking
// the final result of a byte. A byte is registered on entry, its results are
// formed from that register and loaded into the result register, from which
// the first result is offered. While tokens is ready, bytes that yield zero
// or one result are taken every cycle; a byte that yields several results
// holds the single result port until all of them have left, and the next
// byte is taken as the last of them leaves. White space and comment bytes
// yield no result, but they still wait in the input register while the
// results of an earlier byte are leaving.
module c_punctuator_tokenizer #(
  parameter int POS_WIDTH = cpt_pkg::POS_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  cpt_text_if.sink    text,
  cpt_token_if.source tokens
);

  logic                 in_valid;
  logic [7:0]           in_ch;
  logic                 in_end;
  logic                 can_load;
  logic                 advance;
  cpt_pkg::scan_t       st;
  cpt_pkg::scan_t       st_next;
  logic [POS_WIDTH-1:0] line;
  logic [POS_WIDTH-1:0] line_next;
  logic [POS_WIDTH-1:0] col;
  logic [POS_WIDTH-1:0] col_next;
  cpt_pkg::bundle_t     bundle;

  assign advance    = in_valid && can_load;
  assign text.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_ch  <= text.ch;
      in_end <= text.at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.count <= cpt_pkg::HELD_NONE;
      st.held  <= cpt_pkg::CH_NUL;
      st.mode  <= cpt_pkg::MODE_NORMAL;
      st.drop  <= 1'b0;
      line     <= POS_WIDTH'(1);
      col      <= POS_WIDTH'(1);
    end else if (advance) begin
      st   <= st_next;
      line <= line_next;
      col  <= col_next;
    end
  end

  cpt_step #(
    .POS_WIDTH(POS_WIDTH)
  ) u_step (
    .st        (st),
    .line      (line),
    .col       (col),
    .ch        (in_ch),
    .at_end    (in_end),
    .st_next   (st_next),
    .line_next (line_next),
    .col_next  (col_next),
    .bundle    (bundle)
  );

  cpt_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (bundle.cnt != 2'd0)),
    .bundle   (bundle),
    .can_load (can_load),
    .tokens   (tokens)
  );

endmodule

/* rtl/cpt_checker.sv */
// Port-level assertions for the tokenizer and the bind that attaches them.
`timescale 1ns / 1ps
module cpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  result_kind,
  input logic [5:0]  token_type,
  input logic [15:0] err_row,
  input logic [15:0] err_col,
  input logic        run_last
);

  // Token results carry a known code and no position.
  a_token_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == cpt_pkg::RK_TOKEN) |->
      (token_type <= cpt_pkg::TK_MAX) && (err_row == 16'd0) && (err_col == 16'd0))
    else $error("token result with bad code or position");

  // End and error results are always the final result of their request.
  a_final_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != cpt_pkg::RK_TOKEN) |-> run_last && (token_type == 6'd0))
    else $error("end or error result not marked last");

  // Error positions count from one.
  a_err_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((result_kind == cpt_pkg::RK_UNTERM) ||
                  (result_kind == cpt_pkg::RK_BADCHAR)) |->
      (err_row != 16'd0) && (err_col != 16'd0))
    else $error("error result with zero position");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(token_type) && $stable(err_row) && $stable(err_col) && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind c_punctuator_tokenizer cpt_checker u_cpt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .result_kind (tokens.result_kind),
  .token_type  (tokens.token_type),
  .err_row     (tokens.err_row),
  .err_col     (tokens.err_col),
  .run_last    (tokens.run_last)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the C punctuator tokenizer with a scanner model of its own.
`timescale 1ns / 1ps
module tb;
  import cpt_pkg::*;

  localparam int POS_MAX = (1 << POS_WIDTH_DEF) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_TOP = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  ttype;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } tok_rec_t;

  typedef struct {
    logic [7:0] ch;
    logic       at_end;
    bit         pinned;
    int         n_pinned;
    tok_rec_t   pinned_res;
  } feed_t;

  logic clk = 1'b0;
  logic rst;

  cpt_text_if text ();
  cpt_token_if tokens ();

  c_punctuator_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .text(text.sink),
    .tokens(tokens.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scanner state of the model.
  logic [7:0] sc_held;
  int         sc_count;
  logic [1:0] sc_mode;
  int         sc_line;
  int         sc_col;
  bit         sc_drop;

  tok_rec_t step_res[$];
  tok_rec_t tok_due[$];
  feed_t    dir_plan[$];
  feed_t    plan_q[$];

  string punct_chars = "+-*/\\%{}[]()|&^=><!?~,.:;<>&|.=";

  bit idle_on = 1'b1;
  bit hold_ask = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  int fault_count = 0;
  int live_items = 0;
  int byte_count = 0;
  int text_count = 0;
  int res_count = 0;
  int err_seen = 0;

  function automatic int solo_tok(input logic [7:0] c);
    case (c)
      CH_PLUS:   return TK_PLUS;
      CH_MINUS:  return TK_MINUS;
      CH_STAR:   return TK_STAR;
      CH_SLASH:  return TK_SLASH;
      CH_BSLASH: return TK_BSLASH;
      CH_PCT:    return TK_PCT;
      CH_LBRACE: return TK_LBRACE;
      CH_RBRACE: return TK_RBRACE;
      CH_LBRACK: return TK_LBRACK;
      CH_RBRACK: return TK_RBRACK;
      CH_LPAREN: return TK_LPAREN;
      CH_RPAREN: return TK_RPAREN;
      CH_PIPE:   return TK_PIPE;
      CH_AMP:    return TK_AMP;
      CH_CARET:  return TK_CARET;
      CH_EQ:     return TK_ASSIGN;
      CH_GT:     return TK_GT;
      CH_LT:     return TK_LT;
      CH_BANG:   return TK_BANG;
      CH_QUEST:  return TK_QUEST;
      CH_TILDE:  return TK_TILDE;
      CH_COMMA:  return TK_COMMA;
      CH_DOT:    return TK_DOT;
      CH_COLON:  return TK_COLON;
      CH_SEMI:   return TK_SEMI;
      default:   return -1;
    endcase
  endfunction

  function automatic int eq_tok(input logic [7:0] c);
    case (c)
      CH_PLUS:  return TK_ADD_ASSIGN;
      CH_MINUS: return TK_SUB_ASSIGN;
      CH_STAR:  return TK_MUL_ASSIGN;
      CH_SLASH: return TK_DIV_ASSIGN;
      CH_PCT:   return TK_MOD_ASSIGN;
      CH_BANG:  return TK_NE;
      CH_PIPE:  return TK_OR_ASSIGN;
      CH_AMP:   return TK_AND_ASSIGN;
      CH_CARET: return TK_XOR_ASSIGN;
      CH_GT:    return TK_GE;
      CH_LT:    return TK_LE;
      CH_EQ:    return TK_EQEQ;
      default:  return -1;
    endcase
  endfunction

  function automatic int dup_tok(input logic [7:0] c);
    case (c)
      CH_PLUS:  return TK_INC;
      CH_MINUS: return TK_DEC;
      CH_GT:    return TK_SHR;
      CH_LT:    return TK_SHL;
      CH_AMP:   return TK_LAND;
      CH_PIPE:  return TK_LOR;
      default:  return -1;
    endcase
  endfunction

  function automatic int tri_tok(input logic [7:0] c);
    case (c)
      CH_LT:   return TK_SHL_ASSIGN;
      CH_GT:   return TK_SHR_ASSIGN;
      CH_AMP:  return TK_LAND_ASSIGN;
      CH_PIPE: return TK_LOR_ASSIGN;
      default: return -1;
    endcase
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic void reset_scanner();
    sc_held = CH_NUL;
    sc_count = 0;
    sc_mode = MODE_NORMAL;
    sc_line = 1;
    sc_col = 1;
    sc_drop = 1'b0;
  endfunction

  function automatic void add_res(input logic [1:0] k, input int code, input int r, input int c);
    tok_rec_t t;
    if (step_res.size() < 3) begin
      t.kind = k;
      t.ttype = 6'(code);
      t.row = (r > 65535) ? 16'hFFFF : 16'(r);
      t.col = (c > 65535) ? 16'hFFFF : 16'(c);
      t.last = 1'b0;
      step_res.push_back(t);
    end
  endfunction

  function automatic void add_tok(input int code);
    add_res(RK_TOKEN, code, 0, 0);
  endfunction

  function automatic void scan_code(input logic [7:0] c, input int r, input int cl);
    bit again;
    logic [7:0] h;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      h = sc_held;
      if (sc_count == 0) begin
        if (is_ws(c)) begin
        end else if (eq_tok(c) >= 0 || c == CH_DOT) begin
          sc_held = c;
          sc_count = 1;
        end else if (solo_tok(c) >= 0) begin
          add_tok(solo_tok(c));
        end else begin
          add_res(RK_BADCHAR, 0, r, cl);
          sc_drop = 1'b1;
        end
      end else if (sc_count == 1) begin
        sc_count = 0;
        if (h == CH_SLASH && c == CH_SLASH) sc_mode = MODE_LINE;
        else if (h == CH_SLASH && c == CH_STAR) sc_mode = MODE_BLOCK;
        else if (c == CH_EQ && eq_tok(h) >= 0) add_tok(eq_tok(h));
        else if (c == h && (tri_tok(h) >= 0 || h == CH_DOT)) sc_count = 2;
        else if (c == h && dup_tok(h) >= 0) add_tok(dup_tok(h));
        else if (h == CH_MINUS && c == CH_GT) add_tok(TK_ARROW);
        else begin
          add_tok(solo_tok(h));
          again = 1'b1;
        end
      end else begin
        sc_count = 0;
        if (h == CH_DOT) begin
          if (c == CH_DOT) begin
            add_tok(TK_ELLIPSIS);
          end else begin
            add_tok(TK_DOT);
            sc_held = CH_DOT;
            sc_count = 1;
            again = 1'b1;
          end
        end else if (c == CH_EQ) begin
          add_tok(tri_tok(h));
        end else begin
          add_tok(dup_tok(h));
          again = 1'b1;
        end
      end
    end
  endfunction

  function automatic void flush_held();
    if (sc_count == 1) begin
      add_tok(solo_tok(sc_held));
    end else if (sc_count == 2) begin
      if (sc_held == CH_DOT) begin
        add_tok(TK_DOT);
        add_tok(TK_DOT);
      end else begin
        add_tok(dup_tok(sc_held));
      end
    end
    sc_count = 0;
  endfunction

  function automatic void predict_step(input logic [7:0] c, input logic e);
    int r;
    int cl;
    r = sc_line;
    cl = sc_col;
    step_res.delete();
    if (e || c == CH_NUL) begin
      if (!sc_drop) begin
        if (sc_mode == MODE_BLOCK || sc_mode == MODE_BLOCK_STAR) begin
          add_res(RK_UNTERM, 0, r, cl);
        end else begin
          flush_held();
          add_res(RK_END, 0, 0, 0);
        end
      end
      reset_scanner();
    end else begin
      if (!sc_drop) begin
        case (sc_mode)
          MODE_LINE: if (c == CH_LF) sc_mode = MODE_NORMAL;
          MODE_BLOCK: if (c == CH_STAR) sc_mode = MODE_BLOCK_STAR;
          MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) sc_mode = MODE_NORMAL;
            else if (c != CH_STAR) sc_mode = MODE_BLOCK;
          end
          default: scan_code(c, r, cl);
        endcase
      end
      if (c == CH_LF) begin
        if (sc_line < POS_MAX) sc_line++;
        sc_col = 1;
      end else if (sc_col < POS_MAX) begin
        sc_col++;
      end
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  function automatic feed_t scan(input logic [7:0] c, input logic e);
    feed_t f;
    f.ch = c;
    f.at_end = e;
    f.pinned = 1'b0;
    f.n_pinned = 0;
    f.pinned_res = '0;
    return f;
  endfunction

  function automatic feed_t pin(input logic [7:0] c, input logic e, input logic [1:0] k,
                                input logic [5:0] t, input logic [15:0] r, input logic [15:0] cl);
    feed_t f;
    f = scan(c, e);
    f.pinned = 1'b1;
    f.n_pinned = 1;
    f.pinned_res = '{kind: k, ttype: t, row: r, col: cl, last: 1'b1};
    return f;
  endfunction

  function automatic feed_t quiet(input logic [7:0] c, input logic e);
    feed_t f;
    f = scan(c, e);
    f.pinned = 1'b1;
    return f;
  endfunction

  function automatic void take_byte(input feed_t f);
    if (!sc_drop) live_items++;
    byte_count++;
    if (f.at_end || f.ch == CH_NUL) text_count++;
    predict_step(f.ch, f.at_end);
    if (f.pinned) begin
      if (f.n_pinned > 0) tok_due.push_back(f.pinned_res);
    end else begin
      foreach (step_res[i]) tok_due.push_back(step_res[i]);
    end
  endfunction

  task automatic send_item(input feed_t f);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      text.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    text.valid <= 1'b1;
    text.ch <= f.ch;
    text.at_end <= f.at_end;
    do @(posedge clk); while (!text.ready);
    take_byte(f);
  endtask

  task automatic run_plan();
    while (plan_q.size() != 0) send_item(plan_q.pop_front());
  endtask

  function automatic void put(input logic [7:0] c, input logic e);
    plan_q.push_back(scan(c, e));
  endfunction

  function automatic logic [7:0] pick_punct();
    return punct_chars[$urandom_range(0, punct_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] odd_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_ws(c) || solo_tok(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] comment_byte();
    case ($urandom_range(0, 4))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_LF;
      3: return CH_LOW_A;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Builds one text: mostly well-formed punctuator runs and comments, some noise.
  function automatic void gen_text();
    int len;
    int pick;
    logic [7:0] c;
    len = $urandom_range(3, 20);
    if ($urandom_range(0, 9) == 0) begin
      repeat (len) put(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          c = pick_punct();
          repeat ($urandom_range(1, 3)) put(c, 1'b0);
          if ($urandom_range(0, 2) == 0) put(CH_EQ, 1'b0);
        end else if (pick < 70) begin
          put(pick_ws(), 1'b0);
        end else if (pick < 78) begin
          put(CH_SLASH, 1'b0);
          put(CH_SLASH, 1'b0);
          repeat ($urandom_range(1, 6)) put(8'($urandom_range(1, 255)), 1'b0);
          put(CH_LF, 1'b0);
        end else if (pick < 86) begin
          put(CH_SLASH, 1'b0);
          put(CH_STAR, 1'b0);
          repeat ($urandom_range(0, 6)) put(comment_byte(), 1'b0);
          put(CH_STAR, 1'b0);
          put(CH_SLASH, 1'b0);
        end else if (pick < 90) begin
          put(odd_byte(), 1'b0);
        end else begin
          put(pick_punct(), 1'b0);
        end
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        put(CH_SLASH, 1'b0);
        put(CH_STAR, 1'b0);
        repeat ($urandom_range(0, 4)) put(comment_byte(), 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      1, 2, 3, 4: put(8'($urandom_range(0, 255)), 1'b1);
      5, 6, 7: put(CH_NUL, 1'b0);
      default: put(CH_NUL, 1'b1);
    endcase
  endfunction

  task automatic report_fault(input tok_rec_t want, input tok_rec_t got, input bit none);
    if (fault_count < 10) begin
      if (none)
        $display("Mismatch: no result expected, got kind %0d type %0d row %0d col %0d last %0d",
                 got.kind, got.ttype, got.row, got.col, got.last);
      else
        $display({"Mismatch: expected kind %0d type %0d row %0d col %0d last %0d, ",
                  "got %0d %0d %0d %0d %0d"},
                 want.kind, want.ttype, want.row, want.col, want.last,
                 got.kind, got.ttype, got.row, got.col, got.last);
    end
    fault_count++;
  endtask

  task automatic check_result();
    tok_rec_t got;
    tok_rec_t want;
    got.kind = tokens.result_kind;
    got.ttype = tokens.token_type;
    got.row = tokens.err_row;
    got.col = tokens.err_col;
    got.last = tokens.run_last;
    res_count++;
    if (got.kind == RK_UNTERM || got.kind == RK_BADCHAR) err_seen++;
    if (tok_due.size() == 0) begin
      report_fault(got, got, 1'b1);
    end else begin
      want = tok_due.pop_front();
      if (got !== want) report_fault(want, got, 1'b0);
    end
  endtask

  // Result side: checks each accepted result and throttles ready.
  initial begin
    tokens.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tokens.valid && tokens.ready) check_result();
      if (rst) begin
        tokens.ready <= 1'b0;
      end else if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        tokens.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        tokens.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tokens.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        tokens.ready <= 1'b0;
      end else begin
        tokens.ready <= 1'b1;
      end
    end
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int start;
    int guard;
    bit pressed;
    reset_scanner();
    rst <= 1'b1;
    text.valid <= 1'b0;
    text.ch <= CH_NUL;
    text.at_end <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    dir_plan.push_back(pin(CH_DOLLAR, 1'b0, RK_BADCHAR, TK_SHL_ASSIGN, 16'd1, 16'd1));
    dir_plan.push_back(quiet(CH_LOW_X, 1'b0));
    dir_plan.push_back(quiet(CH_LOW_X, 1'b1));
    dir_plan.push_back(pin(CH_TOP, 1'b0, RK_BADCHAR, TK_SHL_ASSIGN, 16'd1, 16'd1));
    dir_plan.push_back(quiet(CH_NUL, 1'b0));
    dir_plan.push_back(pin(CH_SEMI, 1'b0, RK_TOKEN, TK_SEMI, 16'd0, 16'd0));
    dir_plan.push_back(quiet(CH_LT, 1'b0));
    dir_plan.push_back(quiet(CH_LT, 1'b0));
    dir_plan.push_back(pin(CH_EQ, 1'b0, RK_TOKEN, TK_SHL_ASSIGN, 16'd0, 16'd0));
    dir_plan.push_back(scan(CH_DOT, 1'b0));
    dir_plan.push_back(scan(CH_DOT, 1'b0));
    dir_plan.push_back(scan(CH_LOW_X, 1'b0));
    dir_plan.push_back(scan(CH_NUL, 1'b1));
    dir_plan.push_back(scan(CH_SLASH, 1'b0));
    dir_plan.push_back(scan(CH_STAR, 1'b0));
    dir_plan.push_back(scan(CH_SLASH, 1'b0));
    dir_plan.push_back(scan(CH_LF, 1'b0));
    dir_plan.push_back(scan(CH_STAR, 1'b0));
    dir_plan.push_back(scan(CH_STAR, 1'b1));
    dir_plan.push_back(scan(CH_MINUS, 1'b0));
    dir_plan.push_back(scan(CH_GT, 1'b0));
    dir_plan.push_back(scan(CH_AMP, 1'b0));
    dir_plan.push_back(scan(CH_LOW_A, 1'b1));
    dir_plan.push_back(scan(CH_PIPE, 1'b0));
    dir_plan.push_back(scan(CH_PIPE, 1'b0));
    dir_plan.push_back(scan(CH_TOP, 1'b1));
    foreach (dir_plan[i]) send_item(dir_plan[i]);

    start = live_items;
    pressed = 1'b0;
    while (live_items - start < 150) begin
      idle_on = ($urandom_range(0, 3) != 0);
      gen_text();
      run_plan();
      if (!pressed && live_items - start >= 75) begin
        // Results back up behind a long hold while requests keep coming.
        pressed = 1'b1;
        idle_on = 1'b0;
        hold_ask = 1'b1;
        repeat (24) send_item(scan(CH_SEMI, 1'b0));
        send_item(scan(CH_NUL, 1'b1));
        text.valid <= 1'b0;
        while (tok_due.size() != 0) @(posedge clk);
      end
    end

    idle_on = 1'b0;
    send_item(scan(CH_NUL, 1'b1));
    repeat (5) send_item(scan(CH_LF, 1'b0));
    repeat (3) send_item(scan(CH_SPACE, 1'b0));
    send_item(scan(CH_SLASH, 1'b0));
    send_item(scan(CH_STAR, 1'b0));
    send_item(scan(CH_NUL, 1'b1));
    send_item(scan(CH_AT, 1'b0));
    send_item(scan(CH_LOW_X, 1'b1));

    start = live_items;
    while (live_items - start < 20) begin
      gen_text();
      run_plan();
    end
    text.valid <= 1'b0;

    guard = 0;
    while (tok_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (tok_due.size() != 0) begin
      if (fault_count < 10)
        $display("Mismatch: %0d expected results never arrived", tok_due.size());
      fault_count += tok_due.size();
    end

    $display("Run covered %0d source bytes in %0d texts, with rows and columns tracked.",
             byte_count, text_count);
    $display("Checked %0d results, %0d of them error reports; %0d mismatches.",
             res_count, err_seen, fault_count);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
